// File: rtl/stepper_speed_ramp_core_defines.svh
// ----------------------------------------------------------------------------
// Stepper speed ramp: assertion macros
// Shared property forms for the ramp core; every use is clocked on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef STEPPER_SPEED_RAMP_CORE_DEFINES_SVH
`define STEPPER_SPEED_RAMP_CORE_DEFINES_SVH

// Same-cycle implication.
`define SSR_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stepper speed ramp assertion failed");

// Next-cycle implication.
`define SSR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stepper speed ramp assertion failed");

`endif

// File: rtl/ssr_pkg.sv
// ----------------------------------------------------------------------------
// Stepper speed ramp package
// Widths, codes, divider constants and the structs shared by the ramp core.
// ----------------------------------------------------------------------------
package ssr_pkg;

	// Signed rate state width (Q16.8 plus sign at the default of 25).
	localparam int RATE_BITS = 25;

	localparam int REG_W     = 24;
	localparam int VALUE_W   = 25;
	localparam int DT_W      = 16;
	localparam int OPCODE_W  = 2;
	localparam int CFG_IDX_W = 3;

	// Step size is accel * dt / 1000000. The divisor is split into 2^6 * 15625;
	// the shift is free and the odd part goes through a reciprocal multiply.
	localparam int  PROD_W      = REG_W + DT_W;
	localparam int  DIV_SHIFT   = 6;
	localparam int  DIV_ODD     = 15625;
	localparam int  P6_W        = PROD_W - DIV_SHIFT;
	localparam int  LO_W        = (P6_W + 1) / 2;
	localparam int  HI_W        = P6_W - LO_W;
	localparam longint RECIP    = (longint'(1) << P6_W) / DIV_ODD;
	localparam int  RECIP_W     = $clog2(RECIP + 1);
	localparam int  PP_W        = HI_W + RECIP_W + 1;
	localparam int  ODD_W       = $clog2(DIV_ODD + 1);
	localparam int  STEP_W      = $clog2(((longint'(1) << PROD_W) - 1) / 1000000 + 1);
	localparam int  QPROD_W     = STEP_W + ODD_W;

	// Pipeline depth: one input stage plus five divider stages.
	localparam int DIV_STAGES  = 5;
	localparam int PIPE_STAGES = DIV_STAGES + 1;

	// Compare widths for clamping and ramp arithmetic.
	localparam int CMP_W = ((RATE_BITS > VALUE_W) ? RATE_BITS : VALUE_W) + 1;
	localparam int D_W   = ((RATE_BITS > STEP_W) ? RATE_BITS : STEP_W) + 1;
	localparam int MAG_W = RATE_BITS - 1;
	localparam int MIN_W = (MAG_W > REG_W) ? MAG_W : REG_W;

	localparam logic [CMP_W-1:0] RATE_CAP = CMP_W'((longint'(1) << (RATE_BITS - 1)) - 1);
	localparam logic [REG_W-1:0] MAX_RATE_RESET = '1;

	typedef enum logic [OPCODE_W-1:0] {
		OP_TICK       = 2'd0,
		OP_SET_TARGET = 2'd1,
		OP_STOP       = 2'd2,
		OP_SET_ENABLE = 2'd3
	} ssr_op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_RATE      = 3'd0,
		CFG_ACCEL_RATE    = 3'd1,
		CFG_REV_ACCEL     = 3'd2,
		CFG_MIN_RATE      = 3'd3,
		CFG_INVERT_DIR    = 3'd4
	} ssr_cfg_idx_t;

	typedef logic signed [RATE_BITS-1:0] ssr_rate_t;

	typedef struct packed {
		logic [REG_W-1:0] max_rate;
		logic [REG_W-1:0] accel_rate;
		logic [REG_W-1:0] reverse_accel_rate;
		logic [REG_W-1:0] min_rate;
		logic             invert_dir;
	} ssr_cfg_t;

	typedef struct packed {
		ssr_op_t   op;
		ssr_rate_t target;
		logic      enable;
	} ssr_cmd_t;

	typedef struct packed {
		logic             pulse_on;
		logic             dir_level;
		logic [REG_W-1:0] out_rate;
		logic             ramp_reversing;
	} ssr_res_t;

endpackage

// File: rtl/ssr_cmd_if.sv
// ----------------------------------------------------------------------------
// Stepper speed ramp command channel
// Valid/ready channel carrying one command transaction.
// ----------------------------------------------------------------------------
interface ssr_cmd_if import ssr_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [OPCODE_W-1:0]       opcode;
	logic signed [VALUE_W-1:0] value;
	logic [DT_W-1:0]           dt_us;

	modport source (output valid, output opcode, output value, output dt_us, input ready);
	modport sink (input valid, input opcode, input value, input dt_us, output ready);
endinterface

// File: rtl/ssr_res_if.sv
// ----------------------------------------------------------------------------
// Stepper speed ramp result channel
// Valid/ready channel carrying one ramp status transaction.
// ----------------------------------------------------------------------------
interface ssr_res_if import ssr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             pulse_on;
	logic             dir_level;
	logic [REG_W-1:0] out_rate;
	logic             ramp_reversing;

	modport source (output valid, output pulse_on, output dir_level, output out_rate,
		output ramp_reversing, input ready);
	modport sink (input valid, input pulse_on, input dir_level, input out_rate,
		input ramp_reversing, output ready);
endinterface

// File: rtl/ssr_cfg_regs.sv
// ----------------------------------------------------------------------------
// Stepper speed ramp configuration registers
// Write-only register file for limits, accelerations and direction polarity.
// ----------------------------------------------------------------------------
module ssr_cfg_regs import ssr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data,
	output ssr_cfg_t             cfg
);

	ssr_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_rate           <= MAX_RATE_RESET;
			cfg_q.accel_rate         <= '0;
			cfg_q.reverse_accel_rate <= '0;
			cfg_q.min_rate           <= '0;
			cfg_q.invert_dir         <= 1'b0;
		end else if (cfg_wr_en) begin
			case (ssr_cfg_idx_t'(cfg_index))
				CFG_MAX_RATE: begin
					cfg_q.max_rate <= cfg_data;
				end
				CFG_ACCEL_RATE: begin
					cfg_q.accel_rate <= cfg_data;
				end
				CFG_REV_ACCEL: begin
					cfg_q.reverse_accel_rate <= cfg_data;
				end
				CFG_MIN_RATE: begin
					cfg_q.min_rate <= cfg_data;
				end
				CFG_INVERT_DIR: begin
					cfg_q.invert_dir <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/ssr_step_div.sv
// ----------------------------------------------------------------------------
// Stepper speed ramp step divider
// Pipelined accel * dt / 1000000, truncated, in five stages.
// ----------------------------------------------------------------------------
module ssr_step_div import ssr_pkg::*; (
	input  logic                  clk,
	input  logic [DIV_STAGES-1:0] load,
	input  logic [REG_W-1:0]      accel,
	input  logic [DT_W-1:0]       dt_us,
	output logic [STEP_W-1:0]     step
);

	localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
	localparam logic [ODD_W-1:0]   ODD_C   = ODD_W'(DIV_ODD);

	logic [PROD_W-1:0]  prod_s2;
	logic [P6_W-1:0]    p6_s3, p6_s4, p6_s5;
	logic [PP_W-1:0]    pp_hi_s3, pp_lo_s3;
	logic [STEP_W-1:0]  qest_s4, qest_s5, step_s6;
	logic [QPROD_W-1:0] qprod_s5;

	logic [P6_W-1:0] p6;
	logic [PP_W-1:0] pp_sum;
	logic [P6_W-1:0] rem;

	assign p6     = prod_s2[PROD_W-1:DIV_SHIFT];
	// Full product is hi * R * 2^LO_W + lo * R; flooring in two steps is exact.
	assign pp_sum = pp_hi_s3 + (pp_lo_s3 >> LO_W);
	// The estimate is low by at most one, so one compare fixes it.
	assign rem    = p6_s5 - P6_W'(qprod_s5);

	always_ff @(posedge clk) begin
		if (load[0]) begin
			prod_s2 <= PROD_W'(accel) * PROD_W'(dt_us);
		end
		if (load[1]) begin
			p6_s3    <= p6;
			pp_hi_s3 <= PP_W'(p6[P6_W-1:LO_W]) * PP_W'(RECIP_C);
			pp_lo_s3 <= PP_W'(p6[LO_W-1:0]) * PP_W'(RECIP_C);
		end
		if (load[2]) begin
			p6_s4   <= p6_s3;
			qest_s4 <= STEP_W'(pp_sum >> (P6_W - LO_W));
		end
		if (load[3]) begin
			p6_s5    <= p6_s4;
			qest_s5  <= qest_s4;
			qprod_s5 <= QPROD_W'(qest_s4) * QPROD_W'(ODD_C);
		end
		if (load[4]) begin
			step_s6 <= qest_s5 + STEP_W'(rem >= P6_W'(ODD_C));
		end
	end

	assign step = step_s6;

endmodule

// File: rtl/ssr_ramp_update.sv
// ----------------------------------------------------------------------------
// Stepper speed ramp state update
// Holds the ramp state and applies one command per transfer into the result
// register.
// ----------------------------------------------------------------------------
`include "stepper_speed_ramp_core_defines.svh"

module ssr_ramp_update import ssr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              xfer,
	input  ssr_cmd_t          cmd,
	input  logic [STEP_W-1:0] step_acc,
	input  logic [STEP_W-1:0] step_rev,
	input  ssr_cfg_t          cfg,
	output ssr_res_t          res
);

	ssr_rate_t        tgt_q, cur_q;
	logic             rev_q, en_q, dir_q, pulse_q;
	logic [REG_W-1:0] freq_q;
	ssr_res_t         res_q;

	ssr_rate_t        tgt_d, cur_d;
	logic             rev_d, en_d, dir_d, pulse_d;
	logic [REG_W-1:0] freq_d;

	logic                  tgt_pos, tgt_neg, cur_pos, cur_neg;
	logic                  rev_set, use_rev, acc_zero, rev_new, below;
	logic [STEP_W-1:0]     step_sel;
	logic signed [D_W-1:0] tgt_x, cur_x, diff, stp, dlim;
	ssr_rate_t             cur_new;
	logic [RATE_BITS-1:0]  mag_full;
	logic [MAG_W-1:0]      mag;

	// Ramp move for a tick while enabled.
	always_comb begin
		tgt_pos  = !tgt_q[RATE_BITS-1] && (tgt_q != '0);
		tgt_neg  = tgt_q[RATE_BITS-1];
		cur_pos  = !cur_q[RATE_BITS-1] && (cur_q != '0);
		cur_neg  = cur_q[RATE_BITS-1];
		rev_set  = rev_q || (tgt_pos && cur_neg) || (tgt_neg && cur_pos);
		use_rev  = rev_set && (cfg.reverse_accel_rate != '0);
		acc_zero = !use_rev && (cfg.accel_rate == '0);
		step_sel = use_rev ? step_rev : step_acc;

		tgt_x = D_W'(tgt_q);
		cur_x = D_W'(cur_q);
		stp   = $signed(D_W'(step_sel));
		diff  = tgt_x - cur_x;
		if (diff > stp) begin
			dlim = stp;
		end else if (diff < -stp) begin
			dlim = -stp;
		end else begin
			dlim = diff;
		end
		cur_new  = acc_zero ? tgt_q : $signed(RATE_BITS'(cur_x + dlim));
		rev_new  = rev_set && !((tgt_q == '0) || (cur_new == tgt_q));
		mag_full = cur_new[RATE_BITS-1] ? RATE_BITS'(-cur_new) : RATE_BITS'(cur_new);
		mag      = mag_full[MAG_W-1:0];
		below    = MIN_W'(mag) < MIN_W'(cfg.min_rate);
	end

	// Next state per command.
	always_comb begin
		tgt_d   = tgt_q;
		cur_d   = cur_q;
		rev_d   = rev_q;
		en_d    = en_q;
		dir_d   = dir_q;
		pulse_d = pulse_q;
		freq_d  = freq_q;
		case (cmd.op)
			OP_TICK: begin
				if (!en_q) begin
					tgt_d   = '0;
					cur_d   = '0;
					rev_d   = 1'b0;
					pulse_d = 1'b0;
				end else begin
					cur_d = cur_new;
					rev_d = rev_new;
					if (below) begin
						pulse_d = 1'b0;
					end else begin
						dir_d   = !cur_new[RATE_BITS-1] ^ cfg.invert_dir;
						pulse_d = 1'b1;
						freq_d  = REG_W'(mag);
					end
				end
			end
			OP_SET_TARGET: begin
				tgt_d = cmd.target;
			end
			OP_STOP: begin
				tgt_d   = '0;
				cur_d   = '0;
				rev_d   = 1'b0;
				pulse_d = 1'b0;
			end
			OP_SET_ENABLE: begin
				en_d = cmd.enable;
				if (!cmd.enable) begin
					tgt_d   = '0;
					cur_d   = '0;
					rev_d   = 1'b0;
					pulse_d = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_q   <= '0;
			cur_q   <= '0;
			rev_q   <= 1'b0;
			en_q    <= 1'b0;
			dir_q   <= 1'b0;
			pulse_q <= 1'b0;
			freq_q  <= '0;
		end else if (xfer) begin
			tgt_q   <= tgt_d;
			cur_q   <= cur_d;
			rev_q   <= rev_d;
			en_q    <= en_d;
			dir_q   <= dir_d;
			pulse_q <= pulse_d;
			freq_q  <= freq_d;
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			res_q.pulse_on       <= pulse_d;
			res_q.dir_level      <= dir_d;
			res_q.out_rate       <= pulse_d ? freq_d : '0;
			res_q.ramp_reversing <= rev_d;
		end
	end

	assign res = res_q;

	// A disabled axis is always at rest and never mid-reversal.
	`SSR_ASSERT_IMPL(a_disabled_at_rest, !en_q, (cur_q == '0) && !rev_q)
	// A disabled axis never runs the pulse generator.
	`SSR_ASSERT_IMPL(a_disabled_no_pulse, !en_q, !pulse_q)
	// Ramp state only moves when a command reaches the result stage.
	`SSR_ASSERT_NEXT(a_state_holds, !xfer, $stable(cur_q) && $stable(tgt_q) && $stable(en_q))

endmodule

// File: rtl/stepper_speed_ramp_core.sv
// ----------------------------------------------------------------------------
// Stepper speed ramp core
// Signed step-rate ramp generator: commands set a target, stop, enable, or
// advance time, and every command returns the pulse generator settings.
// ----------------------------------------------------------------------------
//
//   Channel   Dir  Handshake         Carries
//   cmd       in   valid/ready       opcode, value, dt_us
//   res       out  valid/ready       pulse_on, dir_level, out_rate, ramp_reversing
//   cfg_*     in   write enable only register index and 24-bit data
//
// One command is accepted per cycle while the input is not stalled, and every
// command yields exactly one result. Each command passes through the input
// stage, the five-stage divider that forms accel * dt_us / 1000000, and the
// state update. Reset is asynchronous and empties the pipeline. A stalled
// result only blocks the input once every pipeline stage is occupied;
// empty stages ahead of a stall keep filling.
// ----------------------------------------------------------------------------
`include "stepper_speed_ramp_core_defines.svh"

module stepper_speed_ramp_core import ssr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	ssr_cmd_if.sink              cmd,
	ssr_res_if.source            res,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data
);

	ssr_cfg_t cfg;

	// Stage occupancy; index 0 is the input stage, the last index feeds the
	// result register.
	logic [PIPE_STAGES-1:0] v_q;
	logic                   res_valid_q;
	// load[k] lets stage k capture; load[PIPE_STAGES] is the result register.
	logic [PIPE_STAGES:0]   load;
	logic                   xfer;

	ssr_op_t                   op_s1;
	logic signed [VALUE_W-1:0] value_s1;
	logic [DT_W-1:0]           dt_s1;
	ssr_cmd_t                  cmd_s2, cmd_s3, cmd_s4, cmd_s5, cmd_s6;

	logic [STEP_W-1:0] step_acc, step_rev;
	ssr_res_t          res_data;

	logic signed [CMP_W-1:0] val_x, lim_x, clamp_x;
	logic [CMP_W-1:0]        max_x;
	ssr_cmd_t                cmd_new;

	ssr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// A stage may take new data when it is empty or its content moves on,
	// so bubbles collapse in front of a stalled result.
	always_comb begin
		load[PIPE_STAGES] = !res_valid_q || res.ready;
		for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
			load[k] = !v_q[k] || load[k+1];
		end
	end

	assign cmd.ready = load[0];
	assign xfer      = load[PIPE_STAGES] && v_q[PIPE_STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (load[0]) begin
				v_q[0] <= cmd.valid;
			end
			for (int k = 1; k < PIPE_STAGES; k++) begin
				if (load[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
			if (load[PIPE_STAGES]) begin
				res_valid_q <= v_q[PIPE_STAGES-1];
			end
		end
	end

	// The target clamp depends only on the command and max_rate, so it is
	// done on the way into stage two, well ahead of the state update.
	always_comb begin
		val_x = CMP_W'(value_s1);
		max_x = CMP_W'(cfg.max_rate);
		lim_x = $signed((max_x < RATE_CAP) ? max_x : RATE_CAP);
		if (val_x > lim_x) begin
			clamp_x = lim_x;
		end else if (val_x < -lim_x) begin
			clamp_x = -lim_x;
		end else begin
			clamp_x = val_x;
		end
		cmd_new.op     = op_s1;
		cmd_new.target = $signed(RATE_BITS'(clamp_x));
		cmd_new.enable = value_s1[0];
	end

	// Command payload travels alongside the divider stages.
	always_ff @(posedge clk) begin
		if (load[0]) begin
			op_s1    <= ssr_op_t'(cmd.opcode);
			value_s1 <= cmd.value;
			dt_s1    <= cmd.dt_us;
		end
		if (load[1]) begin
			cmd_s2 <= cmd_new;
		end
		if (load[2]) begin
			cmd_s3 <= cmd_s2;
		end
		if (load[3]) begin
			cmd_s4 <= cmd_s3;
		end
		if (load[4]) begin
			cmd_s5 <= cmd_s4;
		end
		if (load[5]) begin
			cmd_s6 <= cmd_s5;
		end
	end

	// Both candidate steps are formed; the state stage picks the reverse one when
	// a reversal is under way and reverse_accel_rate is nonzero, else the other.
	ssr_step_div u_div_acc (
		.clk   (clk),
		.load  (load[DIV_STAGES:1]),
		.accel (cfg.accel_rate),
		.dt_us (dt_s1),
		.step  (step_acc)
	);

	ssr_step_div u_div_rev (
		.clk   (clk),
		.load  (load[DIV_STAGES:1]),
		.accel (cfg.reverse_accel_rate),
		.dt_us (dt_s1),
		.step  (step_rev)
	);

	ssr_ramp_update u_update (
		.clk      (clk),
		.arst_n   (arst_n),
		.xfer     (xfer),
		.cmd      (cmd_s6),
		.step_acc (step_acc),
		.step_rev (step_rev),
		.cfg      (cfg),
		.res      (res_data)
	);

	assign res.valid          = res_valid_q;
	assign res.pulse_on       = res_data.pulse_on;
	assign res.dir_level      = res_data.dir_level;
	assign res.out_rate       = res_data.out_rate;
	assign res.ramp_reversing = res_data.ramp_reversing;

	// The input only stalls when every stage holds a command.
	`SSR_ASSERT_IMPL(a_stall_only_when_full, !cmd.ready, (&v_q) && res_valid_q)
	// An accepted command occupies the input stage next cycle.
	`SSR_ASSERT_NEXT(a_accept_fills_s1, cmd.valid && cmd.ready, v_q[0])
	// A new result always comes from an occupied last stage.
	`SSR_ASSERT_IMPL(a_result_source, $rose(res_valid_q), $past(v_q[PIPE_STAGES-1]))

endmodule
